[hdl/disk_collision_time_defines.svh]
// assertion macros for the disk collision time unit
`ifndef DISK_COLLISION_TIME_DEFINES_SVH
`define DISK_COLLISION_TIME_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define DCT_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define DCT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/dct_pkg.sv]
// shared constants and register codes for the disk collision time unit
`timescale 1ns / 1ps

package dct_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    REG_BOX_WIDTH   = 2'd0,
    REG_BOX_HEIGHT  = 2'd1,
    REG_DISK_RADIUS = 2'd2
  } reg_idx_t;

endpackage

[hdl/disk_collision_time.sv]
// disk collision time unit: wall and pair collision times in a deep pipeline
//
//   channel  direction  handshake              payload
//   in       into       in_valid / in_ready    cmd, first_*, second_*
//   out      out of     out_valid / out_ready  hit_time, no_hit
//   config   into       psel/penable/pready    paddr, pwdata, prdata
//
// one transaction per cycle sustained while the skid entry is empty; the pipeline
// depth is set mostly by the square root (one root bit per stage) and the divider
// (one quotient bit per stage)
// rst clears all valid bits and the config registers only; no clearing pass
// a two-entry output register and skid stage let the input take a transaction while
// a result waits; the whole pipeline holds only when the skid entry is occupied
`timescale 1ns / 1ps
`include "disk_collision_time_defines.svh"

module disk_collision_time #(
  parameter int WORD_WIDTH = dct_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = dct_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [((WORD_WIDTH > 33) ? 5 : 4)-1:0]      paddr,
  input  logic [((WORD_WIDTH > 33) ? 64 : 32)-1:0]    pwdata,
  output logic [((WORD_WIDTH > 33) ? 64 : 32)-1:0]    prdata,
  output logic                                        pready,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic                                        cmd,
  input  logic signed [WORD_WIDTH-1:0]                first_x,
  input  logic signed [WORD_WIDTH-1:0]                first_y,
  input  logic signed [WORD_WIDTH-1:0]                first_vx,
  input  logic signed [WORD_WIDTH-1:0]                first_vy,
  input  logic signed [WORD_WIDTH-1:0]                second_x,
  input  logic signed [WORD_WIDTH-1:0]                second_y,
  input  logic signed [WORD_WIDTH-1:0]                second_vx,
  input  logic signed [WORD_WIDTH-1:0]                second_vy,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [WORD_WIDTH-1:0]                       hit_time,
  output logic                                        no_hit
);
  import dct_pkg::*;

  localparam int W      = WORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int APB_DW = (W > 33) ? 64 : 32;
  localparam int ASTEP  = (APB_DW == 64) ? 3 : 2;
  localparam int AW     = ASTEP + 2;
  localparam int PW     = 2 * W + 1;
  localparam int PS     = PW + 1;
  localparam int L      = (PW + 2) / 3;
  localparam int PRD    = 6 * L;
  localparam int DW     = 2 * PW + 1;
  localparam int SR     = (DW + 2 * F + 1) / 2;
  localparam int TW     = SR + 3;
  localparam int NW     = ((PW + F > SR) ? PW + F : SR) + 1;
  localparam int CW     = (NW > PW + W) ? NW : PW + W;

  typedef struct packed {
    logic          pair;
    logic          nohit;
    logic          zero;
    logic          bneg;
    logic          cneg;
    logic          czero;
    logic [PW-1:0] bmag;
    logic [PW-1:0] amag;
  } trk_t;

  typedef struct packed {
    trk_t            t;
    logic [2*SR-1:0] rad;
    logic [TW-1:0]   rem;
    logic [SR-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic          nohit;
    logic          zero;
    logic          sat;
    logic [NW-1:0] rem;
    logic [PW-1:0] den;
    logic [W-1:0]  q;
  } dv_t;

  // configuration
  logic [W-2:0]  box_width;
  logic [W-2:0]  box_height;
  logic [W-2:0]  disk_radius;
  reg_idx_t      cfg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[AW-1:ASTEP]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width   <= '0;
      box_height  <= '0;
      disk_radius <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BOX_WIDTH:   box_width   <= pwdata[W-2:0];
        REG_BOX_HEIGHT:  box_height  <= pwdata[W-2:0];
        REG_DISK_RADIUS: disk_radius <= pwdata[W-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BOX_WIDTH:   prdata = APB_DW'(box_width);
      REG_BOX_HEIGHT:  prdata = APB_DW'(box_height);
      REG_DISK_RADIUS: prdata = APB_DW'(disk_radius);
      default:         prdata = '0;
    endcase
  end

  // pipeline control
  logic          en;
  logic          sk_v;
  logic [7:0]    fv;
  logic [SR:0]   sq_v;
  logic          s9_v;
  logic [W:0]    dv_v;

  assign en       = !sk_v;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv   <= '0;
      sq_v <= '0;
      s9_v <= 1'b0;
      dv_v <= '0;
    end else if (en) begin
      fv   <= {fv[6:0], in_valid};
      sq_v <= {sq_v[SR-1:0], fv[7]};
      s9_v <= sq_v[SR];
      dv_v <= {dv_v[W-1:0], s9_v};
    end
  end

  // stage 0: input capture
  logic                s0_pair;
  logic signed [W-1:0] s0_x1, s0_y1, s0_vx1, s0_vy1, s0_x2, s0_y2, s0_vx2, s0_vy2;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_pair <= cmd;
      s0_x1   <= first_x;
      s0_y1   <= first_y;
      s0_vx1  <= first_vx;
      s0_vy1  <= first_vy;
      s0_x2   <= second_x;
      s0_y2   <= second_y;
      s0_vx2  <= second_vx;
      s0_vy2  <= second_vy;
    end
  end

  // stage 1: differences and wall distances
  logic                s1_pair;
  logic signed [W:0]   s1_dx, s1_dy, s1_wx, s1_wy;
  logic signed [W+1:0] s1_nx, s1_ny;
  logic signed [W-1:0] s1_vx, s1_vy;
  logic [W-1:0]        s1_r2;
  logic [W+1:0]        bw_e, bh_e, r_e, x_e, y_e;
  logic                vx_pos, vy_pos;

  always_comb begin
    bw_e   = {3'b000, box_width};
    bh_e   = {3'b000, box_height};
    r_e    = {3'b000, disk_radius};
    x_e    = {{2{s0_x1[W-1]}}, s0_x1};
    y_e    = {{2{s0_y1[W-1]}}, s0_y1};
    vx_pos = !s0_vx1[W-1] && (s0_vx1 != '0);
    vy_pos = !s0_vy1[W-1] && (s0_vy1 != '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pair <= s0_pair;
      s1_dx   <= {s0_x2[W-1], s0_x2} - {s0_x1[W-1], s0_x1};
      s1_dy   <= {s0_y2[W-1], s0_y2} - {s0_y1[W-1], s0_y1};
      s1_wx   <= {s0_vx2[W-1], s0_vx2} - {s0_vx1[W-1], s0_vx1};
      s1_wy   <= {s0_vy2[W-1], s0_vy2} - {s0_vy1[W-1], s0_vy1};
      s1_nx   <= vx_pos ? bw_e - r_e - x_e : r_e - x_e;
      s1_ny   <= vy_pos ? bh_e - r_e - y_e : r_e - y_e;
      s1_vx   <= s0_vx1;
      s1_vy   <= s0_vy1;
      s1_r2   <= {disk_radius, 1'b0};
    end
  end

  // stage 2: squares and dot terms, wall magnitudes
  logic                 s2_pair;
  logic signed [PS-1:0] s2_wxx, s2_wyy, s2_dwx, s2_dwy, s2_dxx, s2_dyy;
  logic [2*W-1:0]       s2_r4;
  logic [W:0]           s2_nmx, s2_nmy;
  logic [W-1:0]         s2_vmx, s2_vmy;
  logic                 s2_hx, s2_hy, s2_px, s2_py;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pair <= s1_pair;
      s2_wxx  <= PS'(s1_wx) * PS'(s1_wx);
      s2_wyy  <= PS'(s1_wy) * PS'(s1_wy);
      s2_dwx  <= PS'(s1_dx) * PS'(s1_wx);
      s2_dwy  <= PS'(s1_dy) * PS'(s1_wy);
      s2_dxx  <= PS'(s1_dx) * PS'(s1_dx);
      s2_dyy  <= PS'(s1_dy) * PS'(s1_dy);
      s2_r4   <= (2*W)'(s1_r2) * (2*W)'(s1_r2);
      s2_nmx  <= s1_nx[W+1] ? (W+1)'(-s1_nx) : (W+1)'(s1_nx);
      s2_nmy  <= s1_ny[W+1] ? (W+1)'(-s1_ny) : (W+1)'(s1_ny);
      s2_vmx  <= s1_vx[W-1] ? W'(-s1_vx) : W'(s1_vx);
      s2_vmy  <= s1_vy[W-1] ? W'(-s1_vy) : W'(s1_vy);
      s2_hx   <= s1_vx != '0;
      s2_hy   <= s1_vy != '0;
      s2_px   <= (s1_vx != '0) && (s1_nx != '0) && (s1_nx[W+1] != s1_vx[W-1]);
      s2_py   <= (s1_vy != '0) && (s1_ny != '0) && (s1_ny[W+1] != s1_vy[W-1]);
    end
  end

  // stage 3: quadratic coefficients, wall cross products
  logic                 s3_pair;
  logic signed [PS-1:0] s3_a, s3_b, s3_c;
  logic [2*W:0]         s3_cx, s3_cy;
  logic [W:0]           s3_nmx, s3_nmy;
  logic [W-1:0]         s3_vmx, s3_vmy;
  logic                 s3_hx, s3_hy, s3_px, s3_py;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pair <= s2_pair;
      s3_a    <= s2_wxx + s2_wyy;
      s3_b    <= s2_dwx + s2_dwy;
      s3_c    <= s2_dxx + s2_dyy - PS'(s2_r4);
      s3_cx   <= (2*W+1)'(s2_nmx) * (2*W+1)'(s2_vmy);
      s3_cy   <= (2*W+1)'(s2_nmy) * (2*W+1)'(s2_vmx);
      s3_nmx  <= s2_nmx;
      s3_nmy  <= s2_nmy;
      s3_vmx  <= s2_vmx;
      s3_vmy  <= s2_vmy;
      s3_hx   <= s2_hx;
      s3_hy   <= s2_hy;
      s3_px   <= s2_px;
      s3_py   <= s2_py;
    end
  end

  // stage 4: magnitudes and signs, wall axis choice
  trk_t          s4_t, s4_nx;
  logic [PW-1:0] s4_cm, s4_cm_nx;
  logic          pick_x;

  always_comb begin
    pick_x = s3_hx && (!s3_hy || (s3_cx <= s3_cy));
    s4_nx  = '0;
    s4_cm_nx = '0;
    s4_nx.pair = s3_pair;
    if (s3_pair) begin
      s4_nx.bneg  = s3_b[PS-1];
      s4_nx.cneg  = s3_c[PS-1];
      s4_nx.czero = s3_c == '0;
      s4_nx.bmag  = s3_b[PS-1] ? PW'(-s3_b) : PW'(s3_b);
      s4_nx.amag  = s3_a[PW-1:0];
      s4_nx.nohit = (s3_a[PW-1:0] == '0) || (!s3_b[PS-1] && !s3_c[PS-1]);
      s4_cm_nx    = s3_c[PS-1] ? PW'(-s3_c) : PW'(s3_c);
    end else begin
      s4_nx.bmag  = pick_x ? PW'(s3_nmx) : PW'(s3_nmy);
      s4_nx.amag  = pick_x ? PW'(s3_vmx) : PW'(s3_vmy);
      s4_nx.nohit = !s3_hx && !s3_hy;
      s4_nx.zero  = (s3_hx && s3_px) || (s3_hy && s3_py);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_t  <= s4_nx;
      s4_cm <= s4_cm_nx;
    end
  end

  // stage 5: limb partial products of bh*bh and a*c
  logic [L-1:0]   lb [3];
  logic [L-1:0]   la [3];
  logic [L-1:0]   lc [3];
  logic [3*L-1:0] bext, aext, cext;
  logic [2*L-1:0] s5_pb [3][3];
  logic [2*L-1:0] s5_pa [3][3];
  trk_t           s5_t;

  always_comb begin
    bext = (3*L)'(s4_t.bmag);
    aext = (3*L)'(s4_t.amag);
    cext = (3*L)'(s4_cm);
    for (int i = 0; i < 3; i++) begin
      lb[i] = bext[L*i +: L];
      la[i] = aext[L*i +: L];
      lc[i] = cext[L*i +: L];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_t <= s4_t;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s5_pb[i][j] <= (2*L)'(lb[i]) * (2*L)'(lb[j]);
          s5_pa[i][j] <= (2*L)'(la[i]) * (2*L)'(lc[j]);
        end
      end
    end
  end

  // stage 6: row sums
  logic [PRD-1:0] rb [3];
  logic [PRD-1:0] ra [3];
  logic [PRD-1:0] s6_rb [3];
  logic [PRD-1:0] s6_ra [3];
  trk_t           s6_t;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rb[i] = '0;
      ra[i] = '0;
      for (int j = 0; j < 3; j++) begin
        rb[i] = rb[i] + (PRD'(s5_pb[i][j]) << (L*j));
        ra[i] = ra[i] + (PRD'(s5_pa[i][j]) << (L*j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_t <= s5_t;
      for (int i = 0; i < 3; i++) begin
        s6_rb[i] <= rb[i];
        s6_ra[i] <= ra[i];
      end
    end
  end

  // stage 7: full products
  logic [PRD-1:0] pb, pa, s7_pb, s7_pa;
  trk_t           s7_t;

  always_comb begin
    pb = '0;
    pa = '0;
    for (int i = 0; i < 3; i++) begin
      pb = pb + (s6_rb[i] << (L*i));
      pa = pa + (s6_ra[i] << (L*i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_t  <= s6_t;
      s7_pb <= pb;
      s7_pa <= pa;
    end
  end

  // stage 8: discriminant, radicand scaled by 2^(2F)
  sq_t             sq [0:SR];
  logic [2*PW-1:0] bb, ac;
  logic [DW-1:0]   disc;
  logic            dneg;
  trk_t            s8_t;

  always_comb begin
    bb   = s7_pb[2*PW-1:0];
    ac   = s7_pa[2*PW-1:0];
    disc = s7_t.cneg ? DW'(bb) + DW'(ac) : DW'(bb) - DW'(ac);
    dneg = !s7_t.cneg && (bb < ac);
    s8_t = s7_t;
    s8_t.nohit = s7_t.nohit || (s7_t.pair && dneg);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].t    <= s8_t;
      sq[0].rad  <= (2*SR)'({disc, {(2*F){1'b0}}});
      sq[0].rem  <= '0;
      sq[0].root <= '0;
    end
  end

  // square root, one root bit per stage
  for (genvar k = 1; k <= SR; k++) begin : g_sqrt
    logic [TW-1:0] trial, sub;

    always_comb begin
      trial = {sq[k-1].rem[TW-3:0], sq[k-1].rad[2*SR-1 -: 2]};
      sub   = TW'({sq[k-1].root, 2'b01});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[k].t   <= sq[k-1].t;
        sq[k].rad <= {sq[k-1].rad[2*SR-3:0], 2'b00};
        if (trial >= sub) begin
          sq[k].rem  <= trial - sub;
          sq[k].root <= {sq[k-1].root[SR-2:0], 1'b1};
        end else begin
          sq[k].rem  <= trial;
          sq[k].root <= {sq[k-1].root[SR-2:0], 1'b0};
        end
      end
    end
  end

  // stage 9: numerator of the chosen root
  dv_t           s9;
  logic [NW-1:0] num_m, num_s, num;
  trk_t          tr;

  always_comb begin
    tr    = sq[SR].t;
    num_m = NW'({tr.bmag, {F{1'b0}}});
    num_s = NW'(sq[SR].root);
    if (!tr.pair) begin
      num = num_m;
    end else if (tr.bneg && !tr.cneg && !tr.czero) begin
      num = num_m - num_s - NW'(sq[SR].rem != '0);
    end else if (tr.bneg) begin
      num = num_m + num_s;
    end else begin
      num = num_s - num_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9.nohit <= tr.nohit;
      s9.zero  <= tr.zero;
      s9.sat   <= 1'b0;
      s9.rem   <= num;
      s9.den   <= tr.amag;
      s9.q     <= '0;
    end
  end

  // stage 10: saturation check
  dv_t dv [0:W];

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].nohit <= s9.nohit;
      dv[0].zero  <= s9.zero;
      dv[0].sat   <= CW'(s9.rem) >= CW'({s9.den, {W{1'b0}}});
      dv[0].rem   <= s9.rem;
      dv[0].den   <= s9.den;
      dv[0].q     <= s9.q;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 1; k <= W; k++) begin : g_div
    logic [CW-1:0] sh;
    logic          ge;
    logic [W-1:0]  q_next;

    always_comb begin
      sh     = CW'(dv[k-1].den) << (W - k);
      ge     = CW'(dv[k-1].rem) >= sh;
      q_next = dv[k-1].q;
      q_next[W-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k].nohit <= dv[k-1].nohit;
        dv[k].zero  <= dv[k-1].zero;
        dv[k].sat   <= dv[k-1].sat;
        dv[k].den   <= dv[k-1].den;
        dv[k].q     <= q_next;
        dv[k].rem   <= ge ? NW'(CW'(dv[k-1].rem) - sh) : dv[k-1].rem;
      end
    end
  end

  // output register and skid entry
  logic [W-1:0] f_time, sk_time;
  logic         f_nohit, sk_nohit;
  logic         push, pop;

  always_comb begin
    f_nohit = dv[W].nohit;
    if (dv[W].nohit || (!dv[W].zero && dv[W].sat)) begin
      f_time = '1;
    end else if (dv[W].zero) begin
      f_time = '0;
    end else begin
      f_time = dv[W].q;
    end
    push = en && dv_v[W];
    pop  = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_v      <= 1'b0;
    end else if (sk_v) begin
      if (pop) begin
        sk_v <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        sk_v <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v) begin
      if (pop) begin
        hit_time <= sk_time;
        no_hit   <= sk_nohit;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        hit_time <= f_time;
        no_hit   <= f_nohit;
      end else begin
        sk_time  <= f_time;
        sk_nohit <= f_nohit;
      end
    end
  end

  `DCT_ASSERT_NOW(a_skid_has_out, sk_v, out_valid, "skid entry held without output")
  `DCT_ASSERT_NOW(a_nohit_max, out_valid && no_hit, &hit_time, "no hit without max time")
  `DCT_ASSERT_NEXT(a_hold_last, sk_v && dv_v[W], dv_v[W], "last stage lost while held")
  `DCT_ASSERT_NOW(a_zero_speed, fv[4] && s4_t.pair && (s4_t.amag == '0), s4_t.nohit,
                  "zero relative speed not flagged")

endmodule

[test/tb_top.sv]
// self-checking testbench for the disk collision time unit
`timescale 1ns / 1ps

module tb_top;
  import dct_pkg::*;

  localparam int LATENCY    = 3 * WORD_WIDTH_DEF + FRAC_BITS_DEF + 13;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 600;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [319:0] wide_t;
  typedef logic [319:0] uwide_t;

  typedef struct {
    logic cmd;
    q16_t p[8];
  } query_t;

  typedef struct {
    logic [31:0] hit_time;
    logic        no_hit;
  } answer_t;

  typedef struct {
    query_t  q;
    logic    typed;
    answer_t ans;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic cmd = 0;
  q16_t first_x = 0, first_y = 0, first_vx = 0, first_vy = 0;
  q16_t second_x = 0, second_y = 0, second_vx = 0, second_vy = 0;
  logic out_valid, out_ready = 0;
  logic [31:0] hit_time;
  logic no_hit;

  logic [30:0] box_w = 0, box_h = 0, radius = 0;
  answer_t expected_answers[$];
  row_t dir_rows[$];
  int errors = 0, idle_cycles = 0;
  int n_wall = 0, n_pair = 0, n_nohit = 0, n_results = 0;
  bit hold_req = 0, calm = 0;

  disk_collision_time i_dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic bit axis_time(q16_t pos, q16_t vel, logic [30:0] ext,
                                   output logic [31:0] t);
    logic signed [63:0] num, v64;
    logic [63:0] an, av;
    logic [127:0] qt;
    t = '0;
    if (vel == 0) return 0;
    v64 = vel;
    if (vel > 0) num = $signed({33'b0, ext}) - $signed({33'b0, radius}) - 64'(pos);
    else num = $signed({33'b0, radius}) - 64'(pos);
    if (num != 0 && ((num < 0) != (vel < 0))) return 1;
    an = num < 0 ? -num : num;
    av = v64 < 0 ? -v64 : v64;
    qt = (128'(an) << FRAC_BITS_DEF) / 128'(av);
    t = qt > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : qt[31:0];
    return 1;
  endfunction

  function automatic uwide_t int_sqrt(uwide_t n);
    uwide_t r, c;
    r = '0;
    for (int b = 159; b >= 0; b--) begin
      c = r | (uwide_t'(1) << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic answer_t predict_collision(query_t q);
    answer_t a;
    logic [31:0] tx, ty;
    bit hx, hy, hit;
    wide_t dx, dy, wx, wy, sa, bh, sc, dd, rr;
    uwide_t m, s, s2, num, qt;
    a.hit_time = 32'hFFFF_FFFF;
    hit = 0;
    if (!q.cmd) begin
      hx = axis_time(q.p[0], q.p[2], box_w, tx);
      hy = axis_time(q.p[1], q.p[3], box_h, ty);
      hit = hx || hy;
      if (hx && hy) a.hit_time = tx < ty ? tx : ty;
      else if (hx) a.hit_time = tx;
      else if (hy) a.hit_time = ty;
    end else begin
      dx = wide_t'(q.p[4]) - wide_t'(q.p[0]);
      dy = wide_t'(q.p[5]) - wide_t'(q.p[1]);
      wx = wide_t'(q.p[6]) - wide_t'(q.p[2]);
      wy = wide_t'(q.p[7]) - wide_t'(q.p[3]);
      sa = wx * wx + wy * wy;
      bh = dx * wx + dy * wy;
      rr = $signed({289'b0, radius}) << 1;
      sc = dx * dx + dy * dy - rr * rr;
      dd = bh * bh - sa * sc;
      if (sa != 0 && dd >= 0) begin
        m = (bh < 0 ? -bh : bh) << FRAC_BITS_DEF;
        s2 = uwide_t'(dd) << (2 * FRAC_BITS_DEF);
        s = int_sqrt(s2);
        hit = 1;
        if (bh < 0 && sc > 0) begin
          if (s * s != s2) s = s + 1;
          num = m - s;
        end else if (bh < 0) num = m + s;
        else if (sc < 0) num = s - m;
        else hit = 0;
        if (hit) begin
          qt = num / uwide_t'(sa);
          a.hit_time = qt > 320'hFFFF_FFFF ? 32'hFFFF_FFFF : qt[31:0];
        end
      end
    end
    if (!hit) a.hit_time = 32'hFFFF_FFFF;
    a.no_hit = !hit;
    return a;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 4'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_BOX_WIDTH:   box_w = value[30:0];
      REG_BOX_HEIGHT:  box_h = value[30:0];
      REG_DISK_RADIUS: radius = value[30:0];
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic send_query(query_t q, bit typed, answer_t ans);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd <= q.cmd;
    first_x <= q.p[0]; first_y <= q.p[1]; first_vx <= q.p[2]; first_vy <= q.p[3];
    second_x <= q.p[4]; second_y <= q.p[5]; second_vx <= q.p[6]; second_vy <= q.p[7];
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_answers.push_back(typed ? ans : predict_collision(q));
    if (q.cmd) n_pair++;
    else n_wall++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic q16_t small_val(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int kind;
    kind = $urandom_range(0, 9);
    q.cmd = $urandom_range(0, 1);
    for (int i = 0; i < 8; i++) begin
      if (kind < 2) q.p[i] = $urandom;
      else if (i % 4 < 2) q.p[i] = small_val(200 << 16);
      else q.p[i] = small_val(kind < 5 ? 40 << 16 : 4 << 12);
    end
    if (kind == 9) begin
      q.p[2 + $urandom_range(0, 1)] = 0;
      if ($urandom_range(0, 1)) begin
        q.p[6] = q.p[2];
        q.p[7] = q.p[3];
      end
    end
    return q;
  endfunction

  task automatic add_row(logic c, q16_t a0, q16_t a1, q16_t a2, q16_t a3,
                         q16_t a4, q16_t a5, q16_t a6, q16_t a7,
                         logic typed, logic [31:0] t, logic nh);
    row_t r;
    r.q.cmd = c;
    r.q.p = '{a0, a1, a2, a3, a4, a5, a6, a7};
    r.typed = typed;
    r.ans.hit_time = t;
    r.ans.no_hit = nh;
    dir_rows.push_back(r);
  endtask

  localparam q16_t MAXV = 32'sh7FFF_FFFF;
  localparam q16_t MINV = -32'sh8000_0000;
  localparam q16_t ONE = 32'sh0001_0000;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_answers.size() == 0) begin
        report("unexpected result transaction", hit_time, 32'hFFFF_FFFF);
      end else begin
        if (hit_time !== expected_answers[0].hit_time)
          report("hit_time", hit_time, expected_answers[0].hit_time);
        if (no_hit !== expected_answers[0].no_hit)
          report("no_hit", 32'(no_hit), 32'(expected_answers[0].no_hit));
        if (no_hit) n_nohit++;
        void'(expected_answers.pop_front());
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 0;
      end else if (stall > 0) begin
        out_ready <= 0;
        stall--;
      end else begin
        out_ready <= 1;
        if (!calm && $urandom_range(0, 3) == 0)
          stall = $urandom_range(0, 15) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("watchdog expired at %0t", $realtime);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    answer_t none;
    none = '{32'h0, 1'b0};
    repeat (5) @(posedge clk);
    rst <= 0;

    // all registers zero after reset
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 1);
    add_row(0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 32'h0, 0);
    add_row(0, 10 * ONE, 0, ONE, 0, 0, 0, 0, 0, 1, 32'h0, 0);
    add_row(1, 0, 0, ONE, ONE, 5 * ONE, 0, ONE, ONE, 1, 32'hFFFF_FFFF, 1);
    add_row(1, 0, 0, 0, 0, 5 * ONE, 0, ONE, 0, 1, 32'hFFFF_FFFF, 1);
    add_row(1, 0, 0, ONE, 0, 5 * ONE, 0, -ONE, 0, 0, 0, 0);
    add_row(0, MINV, MINV, MAXV, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, 0, 0, 0);
    foreach (dir_rows[i]) send_query(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].ans);
    drain();

    write_reg(REG_BOX_WIDTH, 100 << 16);
    write_reg(REG_BOX_HEIGHT, 80 << 16);
    write_reg(REG_DISK_RADIUS, ONE);
    dir_rows.delete();
    add_row(0, 50 * ONE, 40 * ONE, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 1);
    add_row(0, 50 * ONE, 40 * ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 50 * ONE, 40 * ONE, -ONE, 2 * ONE, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 50 * ONE, 40 * ONE, 1, -1, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 200 * ONE, 40 * ONE, ONE, 0, 0, 0, 0, 0, 1, 32'h0, 0);
    add_row(1, 0, 0, ONE, 0, 10 * ONE, 0, -ONE, 0, 0, 0, 0);
    add_row(1, 0, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, 0);
    add_row(1, 0, 0, ONE, 0, 10 * ONE, 3 * ONE, -ONE, 0, 0, 0, 0);
    add_row(1, 0, 0, ONE, 0, 10 * ONE, 0, 2 * ONE, 0, 1, 32'hFFFF_FFFF, 1);
    add_row(1, 0, 0, 1, 0, MAXV, 0, 0, 0, 0, 0, 0);
    foreach (dir_rows[i]) send_query(dir_rows[i].q, dir_rows[i].typed, dir_rows[i].ans);

    hold_req = 1;
    repeat (150) send_query(random_query(), 0, none);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_BOX_WIDTH, 32'hFFFF_FFFF);
          write_reg(REG_BOX_HEIGHT, 32'h7FFF_FFFF);
          write_reg(REG_DISK_RADIUS, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(REG_BOX_WIDTH, $urandom);
          write_reg(REG_BOX_HEIGHT, $urandom);
          write_reg(REG_DISK_RADIUS, $urandom_range(0, 8 << 16));
        end
        2: begin
          calm = 1;
          write_reg(REG_BOX_WIDTH, 300 << 16);
          write_reg(REG_BOX_HEIGHT, 1);
          write_reg(REG_DISK_RADIUS, 0);
        end
        default: begin
          calm = 0;
          write_reg(REG_BOX_WIDTH, 400 << 16);
          write_reg(REG_BOX_HEIGHT, 400 << 16);
          write_reg(REG_DISK_RADIUS, 3 << 16);
        end
      endcase
      repeat (150) send_query(random_query(), 0, none);
      drain();
    end

    repeat (LATENCY + 25) @(posedge clk);
    $display("covered %0d wall and %0d pair queries over six register settings",
             n_wall, n_pair);
    $display("%0d results checked, %0d of them without a collision", n_results, n_nohit);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/dct_pkg.sv
hdl/disk_collision_time.sv
test/tb_top.sv
